@@ hw/rtl/replica_sync_mode_selector_assert.svh @@
// Assertion macros shared by the replica sync mode selector checkers.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef REPLICA_SYNC_MODE_SELECTOR_ASSERT_SVH
`define REPLICA_SYNC_MODE_SELECTOR_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RSMS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RSMS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/rsms_pkg.sv @@
// Shared constants and types for the replica sync mode selector.
// No dependencies; every other file of the block but the assertion macro header imports this package.
package rsms_pkg;

  localparam int DEF_MAX_REPLICAS = 16;
  localparam int DEF_LAG_BITS     = 32;

  localparam int LAG_IN_W      = 32;
  localparam int REPLICA_IDX_W = 4;
  localparam int LIM_W         = 5;
  localparam int CFG_IDX_W     = 3;
  localparam int RESULT_LIMIT  = 16;
  localparam int NTW           = $clog2(RESULT_LIMIT + 1);

  localparam logic [CFG_IDX_W-1:0] CFG_TRACKER_ENABLED = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LIMIT_GIVEN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SYNC_LIMIT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_LIMIT_GIVEN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SYNC_LIMIT  = 3'd4;

  localparam logic [LIM_W-1:0] MAX_SYNC_LIMIT_RST = 5'd16;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_COUNT,
    ST_PLAN_A,
    ST_PLAN_B,
    ST_PLAN_C,
    ST_PLAN_D,
    ST_ROUTE,
    ST_FIND,
    ST_PROMOTE,
    ST_DEMBAD,
    ST_DEMGOOD,
    ST_MARK,
    ST_DONE
  } state_t;

endpackage

@@ hw/rtl/rsms_if.sv @@
// Valid/ready channel interfaces for replica items and mode-change results.
// Depends on rsms_pkg for the field widths.
interface rsms_in_if import rsms_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                is_sync;
  logic                check_ok;
  logic [LAG_IN_W-1:0] lag;
  logic                last_replica;

  modport source (output valid, output is_sync, output check_ok, output lag,
                  output last_replica, input ready);
  modport sink   (input valid, input is_sync, input check_ok, input lag,
                  input last_replica, output ready);
endinterface

interface rsms_out_if import rsms_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [REPLICA_IDX_W-1:0] replica_index;
  logic                     new_mode;
  logic                     action_valid;
  logic                     overflow;
  logic                     last_action;

  modport source (output valid, output replica_index, output new_mode,
                  output action_valid, output overflow, output last_action,
                  input ready);
  modport sink   (input valid, input replica_index, input new_mode,
                  input action_valid, input overflow, input last_action,
                  output ready);
endinterface

@@ hw/rtl/replica_sync_mode_selector.sv @@
// Throughput: one replica transaction per cycle until the one marked last; the decision then
// walks the store: a counting pass, the planning states PLAN_A to PLAN_D, then per promotion
// a search pass, a promote step and a route step, and the two demotion passes, or a bare end
// marker when there is no action; output stalls hold the walk, and the next table is only
// taken once it is done. Reset (rst_n low, synchronous) empties the table, clears the
// overflow flag and the output valid and returns the configuration to its reset values.
module replica_sync_mode_selector import rsms_pkg::*; #(
  parameter int MAX_REPLICAS = DEF_MAX_REPLICAS,
  parameter int LAG_BITS     = DEF_LAG_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [LIM_W-1:0]     cfg_wdata,
  rsms_in_if.sink              in_ch,
  rsms_out_if.source           out_ch
);

  // Count width holds the capacity itself; the index width addresses one entry.
  localparam int CW = $clog2(MAX_REPLICAS + 1);
  localparam int IW = (MAX_REPLICAS > 1) ? $clog2(MAX_REPLICAS) : 1;
  localparam int MW = (CW > LIM_W) ? CW : LIM_W;
  localparam int EW = LAG_BITS + 2;

  // Configuration registers.
  logic             tracker_enabled_r;
  logic             max_limit_given_r;
  logic [LIM_W-1:0] max_sync_limit_r;
  logic             min_limit_given_r;
  logic [LIM_W-1:0] min_sync_limit_r;

  // Sequencer and scan control.
  state_t        state_r, state_nxt;
  logic          phase_r;
  logic [IW-1:0] scan_idx_r;
  logic [CW-1:0] kcnt_r;
  logic [CW-1:0] count_r;
  logic          ovf_r;
  logic [CW-1:0] gs_r, bs_r, ga_r;
  logic [NTW-1:0] n_r, ntot_r;
  logic          best_found_r;

  // Decision plan, held for the whole run.
  logic [MW-1:0] max_s_r, min_s_r, p_r, d2_r, start_r;

  // Running minimum for the promotion search and the previous pick.
  logic [LAG_BITS-1:0] best_lag_r, prev_lag_r;
  logic [IW-1:0]       best_idx_r, prev_idx_r;

  // Replica store: mode, health and lag in one word; read data registered.
  logic [EW-1:0] mem [MAX_REPLICAS];
  logic [EW-1:0] rd_q_r;

  // Output register.
  logic                     out_valid_r;
  logic [REPLICA_IDX_W-1:0] out_idx_r;
  logic                     out_mode_r, out_act_r, out_ovf_r, out_last_r;

  // Combinational signals.
  logic                         in_acc, store_ok;
  logic [LAG_BITS+LAG_IN_W-1:0] lag_wide;
  logic [LAG_BITS-1:0]          lag_store;
  logic                         rd_sync, rd_ok;
  logic [LAG_BITS-1:0]          rd_lag;
  logic [CW-1:0]                last_idx;
  logic                         scan_last, scanning, member, qualify;
  logic                         stall, step_done, can_emit, room_left;
  logic                         after_prev, better;
  logic [MW-1:0]                gs_ext, bs_ext, ga_ext, kcnt_ext;
  logic [MW-1:0]                max_s_w, room_w, p_w, d2_w, total_w, start_w, d1_w;
  logic [MW+1:0]                nsum_w;
  logic [NTW-1:0]               ntot_w;
  logic                         emit, emit_mode, emit_act, emit_last;
  logic [IW-1:0]                emit_idx;

  // The lag is cut to, or widened to, the stored lag width.
  assign lag_wide  = {{LAG_BITS{1'b0}}, in_ch.lag};
  assign lag_store = lag_wide[LAG_BITS-1:0];

  assign in_ch.ready = (state_r == ST_LOAD);
  assign in_acc      = in_ch.valid && in_ch.ready;
  // Once the store is full further replicas are dropped and only flagged.
  assign store_ok    = (count_r < CW'(MAX_REPLICAS));

  assign rd_sync = rd_q_r[EW-1];
  assign rd_ok   = rd_q_r[EW-2];
  assign rd_lag  = rd_q_r[LAG_BITS-1:0];

  // A decision always has at least one stored replica, so count minus one is the last entry.
  assign last_idx  = count_r - CW'(1);
  assign scan_last = (CW'(scan_idx_r) == last_idx);

  assign can_emit  = !out_valid_r || out_ch.ready;
  assign room_left = (n_r < ntot_r);

  assign gs_ext   = MW'(gs_r);
  assign bs_ext   = MW'(bs_r);
  assign ga_ext   = MW'(ga_r);
  assign kcnt_ext = MW'(kcnt_r);

  // Planning arithmetic, one small step per planning state.
  assign max_s_w = max_limit_given_r ? MW'(max_sync_limit_r) : MW'(count_r);
  assign room_w  = (max_s_r > gs_ext) ? (max_s_r - gs_ext) : '0;
  assign p_w     = (room_w < ga_ext) ? room_w : ga_ext;
  assign d2_w    = (gs_ext > max_s_r) ? (gs_ext - max_s_r) : '0;
  assign total_w = (max_s_r < gs_ext) ? max_s_r : MW'(gs_ext + p_r);
  assign start_w = (min_s_r > total_w) ? (min_s_r - total_w) : '0;
  assign d1_w    = (bs_ext > start_r) ? (bs_ext - start_r) : '0;
  assign nsum_w  = {2'b00, p_r} + {2'b00, d1_w} + {2'b00, d2_r};

  always_comb begin
    if (!tracker_enabled_r) begin
      ntot_w = '0;
    end else if (nsum_w > (MW + 2)'(RESULT_LIMIT)) begin
      ntot_w = NTW'(RESULT_LIMIT);
    end else begin
      ntot_w = NTW'(nsum_w);
    end
  end

  // The promotion search picks the smallest (lag, position) pair that lies strictly above
  // the previous pick, which gives lowest lag first with ties in arrival order.
  assign after_prev = (n_r == '0) || (rd_lag > prev_lag_r) ||
                      ((rd_lag == prev_lag_r) && (scan_idx_r > prev_idx_r));
  assign better     = !rd_sync && rd_ok && after_prev &&
                      (!best_found_r || (rd_lag < best_lag_r));

  always_comb begin
    scanning = state_r inside {ST_COUNT, ST_FIND, ST_DEMBAD, ST_DEMGOOD};
    member   = 1'b0;
    qualify  = 1'b0;
    case (state_r)
      ST_DEMBAD: begin
        member  = rd_sync && !rd_ok;
        qualify = member && (kcnt_ext >= start_r);
      end
      ST_DEMGOOD: begin
        member  = rd_sync && rd_ok;
        qualify = member && (kcnt_ext >= max_s_r);
      end
      default: begin
        member  = 1'b0;
        qualify = 1'b0;
      end
    endcase
    // A demotion found while the output register is still occupied holds the scan.
    stall     = scanning && phase_r && qualify && room_left && !can_emit;
    step_done = scanning && phase_r && !stall;
  end

  // Next-state logic of the sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_LOAD: begin
        if (in_acc && in_ch.last_replica) state_nxt = ST_COUNT;
      end
      ST_COUNT: begin
        if (step_done && scan_last) state_nxt = ST_PLAN_A;
      end
      ST_PLAN_A: state_nxt = ST_PLAN_B;
      ST_PLAN_B: state_nxt = ST_PLAN_C;
      ST_PLAN_C: state_nxt = ST_PLAN_D;
      ST_PLAN_D: state_nxt = ST_ROUTE;
      ST_ROUTE: begin
        if (ntot_r == '0) begin
          state_nxt = ST_MARK;
        end else if (n_r == ntot_r) begin
          state_nxt = ST_DONE;
        end else if (MW'(n_r) < p_r) begin
          state_nxt = ST_FIND;
        end else begin
          state_nxt = ST_DEMBAD;
        end
      end
      ST_FIND: begin
        if (step_done && scan_last) state_nxt = ST_PROMOTE;
      end
      ST_PROMOTE: begin
        if (can_emit) state_nxt = ST_ROUTE;
      end
      ST_DEMBAD: begin
        if (step_done && scan_last) state_nxt = ST_DEMGOOD;
      end
      ST_DEMGOOD: begin
        if (step_done && scan_last) state_nxt = ST_DONE;
      end
      ST_MARK: begin
        if (can_emit) state_nxt = ST_DONE;
      end
      ST_DONE:  state_nxt = ST_LOAD;
      default:  state_nxt = ST_LOAD;
    endcase
  end

  // Result selection: which action, if any, is loaded into the output register.
  always_comb begin
    emit      = 1'b0;
    emit_idx  = scan_idx_r;
    emit_mode = 1'b0;
    emit_act  = 1'b1;
    emit_last = (n_r == (ntot_r - NTW'(1)));
    case (state_r)
      ST_PROMOTE: begin
        emit      = can_emit;
        emit_idx  = best_idx_r;
        emit_mode = 1'b1;
      end
      ST_DEMBAD, ST_DEMGOOD: begin
        emit = phase_r && qualify && room_left && can_emit;
      end
      ST_MARK: begin
        emit      = can_emit;
        emit_idx  = '0;
        emit_act  = 1'b0;
        emit_last = 1'b1;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tracker_enabled_r <= 1'b0;
      max_limit_given_r <= 1'b0;
      max_sync_limit_r  <= MAX_SYNC_LIMIT_RST;
      min_limit_given_r <= 1'b0;
      min_sync_limit_r  <= '0;
      state_r           <= ST_LOAD;
      phase_r           <= 1'b0;
      scan_idx_r        <= '0;
      kcnt_r            <= '0;
      count_r           <= '0;
      ovf_r             <= 1'b0;
      gs_r              <= '0;
      bs_r              <= '0;
      ga_r              <= '0;
      n_r               <= '0;
      ntot_r            <= '0;
      best_found_r      <= 1'b0;
      out_valid_r       <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_TRACKER_ENABLED: tracker_enabled_r <= cfg_wdata[0];
          CFG_MAX_LIMIT_GIVEN: max_limit_given_r <= cfg_wdata[0];
          CFG_MAX_SYNC_LIMIT:  max_sync_limit_r  <= cfg_wdata;
          CFG_MIN_LIMIT_GIVEN: min_limit_given_r <= cfg_wdata[0];
          CFG_MIN_SYNC_LIMIT:  min_sync_limit_r  <= cfg_wdata;
          default: ;
        endcase
      end

      state_r <= state_nxt;

      // Scan walker: address in the first phase, evaluate the read word in the second.
      if (scanning) begin
        if (!phase_r) begin
          phase_r <= 1'b1;
        end else if (!stall) begin
          phase_r <= 1'b0;
          if (scan_last) begin
            scan_idx_r <= '0;
            kcnt_r     <= '0;
          end else begin
            scan_idx_r <= scan_idx_r + IW'(1);
            if (member) kcnt_r <= kcnt_r + CW'(1);
          end
        end
      end else begin
        phase_r    <= 1'b0;
        scan_idx_r <= '0;
        kcnt_r     <= '0;
      end

      if (in_acc) begin
        if (store_ok) begin
          count_r <= count_r + CW'(1);
        end else begin
          ovf_r <= 1'b1;
        end
      end

      case (state_r)
        ST_LOAD: begin
          gs_r <= '0;
          bs_r <= '0;
          ga_r <= '0;
          n_r  <= '0;
        end
        ST_COUNT: begin
          if (phase_r) begin
            if (rd_sync && rd_ok)       gs_r <= gs_r + CW'(1);
            else if (rd_sync)           bs_r <= bs_r + CW'(1);
            else if (rd_ok)             ga_r <= ga_r + CW'(1);
          end
        end
        ST_PLAN_D: ntot_r <= ntot_w;
        ST_DONE: begin
          count_r <= '0;
          ovf_r   <= 1'b0;
        end
        default: ;
      endcase

      if (emit && (state_r != ST_MARK)) n_r <= n_r + NTW'(1);

      if (state_r == ST_FIND) begin
        if (phase_r && better) best_found_r <= 1'b1;
      end else begin
        best_found_r <= 1'b0;
      end

      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Plan, search and output payload registers.
  always_ff @(posedge clk) begin
    case (state_r)
      ST_PLAN_A: begin
        max_s_r <= max_s_w;
        min_s_r <= min_limit_given_r ? MW'(min_sync_limit_r) : max_s_w;
      end
      ST_PLAN_B: begin
        p_r  <= p_w;
        d2_r <= d2_w;
      end
      ST_PLAN_C: start_r <= start_w;
      ST_FIND: begin
        if (phase_r && better) begin
          best_lag_r <= rd_lag;
          best_idx_r <= scan_idx_r;
        end
      end
      ST_PROMOTE: begin
        if (emit) begin
          prev_lag_r <= best_lag_r;
          prev_idx_r <= best_idx_r;
        end
      end
      default: ;
    endcase

    if (emit) begin
      out_idx_r  <= REPLICA_IDX_W'(emit_idx);
      out_mode_r <= emit_mode;
      out_act_r  <= emit_act;
      out_ovf_r  <= ovf_r;
      out_last_r <= emit_last;
    end
  end

  // Store write port and registered read port.
  always_ff @(posedge clk) begin
    if (in_acc && store_ok) begin
      mem[count_r[IW-1:0]] <= {in_ch.is_sync, in_ch.check_ok, lag_store};
    end
  end

  always_ff @(posedge clk) begin
    rd_q_r <= mem[scan_idx_r];
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.replica_index = out_idx_r;
  assign out_ch.new_mode      = out_mode_r;
  assign out_ch.action_valid  = out_act_r;
  assign out_ch.overflow      = out_ovf_r;
  assign out_ch.last_action   = out_last_r;

endmodule

@@ hw/rtl/rsms_checker.sv @@
// Port-level checker for the replica sync mode selector, bound to the top level.
// Depends on rsms_pkg, rsms_if.sv and the macros in replica_sync_mode_selector_assert.svh.
`include "replica_sync_mode_selector_assert.svh"

module rsms_checker import rsms_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  rsms_in_if.sink    in_ch,
  rsms_out_if.source out_ch
);

  logic                     last_acc, mid_acc, out_stall, marker, marker_ok;
  logic [REPLICA_IDX_W+3:0] payload;

  assign last_acc  = in_ch.valid && in_ch.ready && in_ch.last_replica;
  assign mid_acc   = in_ch.valid && in_ch.ready && !in_ch.last_replica;
  assign out_stall = out_ch.valid && !out_ch.ready;
  assign marker    = out_ch.valid && !out_ch.action_valid;
  assign marker_ok = out_ch.last_action && !out_ch.new_mode && (out_ch.replica_index == '0);
  assign payload   = {out_ch.replica_index, out_ch.new_mode, out_ch.action_valid,
                      out_ch.overflow, out_ch.last_action};

  // A stalled result keeps its contents until it is taken.
  `RSMS_ASSERT_NEXT(a_out_hold, out_stall, out_ch.valid && $stable(payload), "result changed")

  // The final replica starts the decision run, so no further replica is taken straight away.
  `RSMS_ASSERT_NEXT(a_last_blocks, last_acc, !in_ch.ready, "input taken during decision")

  // Ordinary replicas keep the loader open for the next transaction.
  `RSMS_ASSERT_NEXT(a_load_open, mid_acc, in_ch.ready, "loader closed after ordinary replica")

  // A bare end marker is always the final result and carries a zero index and mode.
  `RSMS_ASSERT_SAME(a_marker, marker, marker_ok, "malformed end marker")

endmodule

bind replica_sync_mode_selector rsms_checker u_rsms_checker (
  .clk    (clk),
  .rst_n  (rst_n),
  .in_ch  (in_ch),
  .out_ch (out_ch)
);

@@ sim/tb_replica_sync_mode_selector.sv @@
// Self-checking testbench for replica_sync_mode_selector: loads replica tables,
// predicts the mode-change transactions of each decision and checks them in order.
// Depends on rsms_pkg, the rsms_in_if/rsms_out_if interfaces and the block itself.
module tb_replica_sync_mode_selector;
  import rsms_pkg::*;

  localparam int REPLICA_SLOTS = DEF_MAX_REPLICAS;
  // Settling time before a register write and after the final result. The decision walk
  // can go on after its last result, so the idle wait also waits for the loader to reopen.
  localparam int DRAIN_CYCLES  = 40;
  localparam int END_CYCLES    = 200;
  // The longest stretch of a decision with no transaction comes before a result that is a
  // demotion only, and receiver stalls lengthen it; the watchdog allows far more.
  localparam int STALL_LIMIT   = 5000;
  localparam int RANDOM_ITEMS  = 320;
  localparam int PHASES        = 8;

  // One mode-change result as the block presents it.
  typedef struct packed {
    logic [REPLICA_IDX_W-1:0] replica_index;
    logic                     new_mode;
    logic                     action_valid;
    logic                     overflow;
    logic                     last_action;
  } mode_action_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [LIM_W-1:0]     cfg_wdata;

  rsms_in_if  in_ch ();
  rsms_out_if out_ch ();

  replica_sync_mode_selector dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // Our own copy of the replica table, as it stands since the last decision.
  logic                shadow_sync [REPLICA_SLOTS];
  logic                shadow_ok   [REPLICA_SLOTS];
  logic [LAG_IN_W-1:0] shadow_lag  [REPLICA_SLOTS];
  int                  shadow_count;
  logic                shadow_overflow;

  // Our own copy of the configuration registers.
  logic             tracker_on;
  logic             max_given;
  logic [LIM_W-1:0] max_limit;
  logic             min_given;
  logic [LIM_W-1:0] min_limit;

  // Mode-change transactions that have been predicted but not yet seen.
  mode_action_t expected_actions[$];

  int failures;
  int quiet_cycles;
  int idle_pct;   // chance in a hundred that the sender holds back in a cycle
  int stall_pct;  // chance in a hundred that the receiver is not ready in a cycle

  always #5 clk = ~clk;

  // The receiver decides afresh at every edge whether it will take a result.
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99, 0) >= stall_pct);
  end

  // Appends one predicted action unless the decision has already produced its
  // full sixteen; base is the queue depth at which this decision started.
  function automatic void add_action(int base, int idx, logic mode, logic act);
    mode_action_t a;
    if (expected_actions.size() - base >= RESULT_LIMIT) return;
    a.replica_index = idx[REPLICA_IDX_W-1:0];
    a.new_mode      = mode;
    a.action_valid  = act;
    a.overflow      = shadow_overflow;
    a.last_action   = 1'b0;
    expected_actions = {expected_actions, a};
  endfunction

  // Works out the actions of one decision over the stored table. Healthy async
  // replicas are promoted in ascending lag order, ties kept in arrival order; then
  // the unhealthy sync replicas beyond those that the minimum keeps are demoted;
  // finally healthy sync replicas past the maximum are demoted.
  function automatic void plan_mode_changes();
    int good_sync  [REPLICA_SLOTS];
    int bad_sync   [REPLICA_SLOTS];
    int good_async [REPLICA_SLOTS];
    int gs, bs, ga, base, v, j;
    int max_s, min_s, pos, nxt, total, kept_bad;
    gs = 0;
    bs = 0;
    ga = 0;
    base = expected_actions.size();
    for (int i = 0; i < shadow_count; i++) begin
      if (shadow_sync[i]) begin
        if (shadow_ok[i]) good_sync[gs++] = i;
        else bad_sync[bs++] = i;
      end else if (shadow_ok[i]) begin
        good_async[ga++] = i;
      end
    end
    // Stable insertion sort on lag.
    for (int i = 1; i < ga; i++) begin
      v = good_async[i];
      j = i - 1;
      while (j >= 0 && shadow_lag[good_async[j]] > shadow_lag[v]) begin
        good_async[j + 1] = good_async[j];
        j--;
      end
      good_async[j + 1] = v;
    end
    max_s = max_given ? int'(max_limit) : shadow_count;
    min_s = min_given ? int'(min_limit) : max_s;
    if (tracker_on) begin
      pos = gs;
      nxt = 0;
      while (pos < max_s && nxt < ga) begin
        add_action(base, good_async[nxt], 1'b1, 1'b1);
        nxt++;
        pos++;
      end
      total = (max_s < gs) ? max_s : pos;
      kept_bad = (min_s > total) ? min_s - total : 0;
      for (int i = kept_bad; i < bs; i++) add_action(base, bad_sync[i], 1'b0, 1'b1);
      for (int i = max_s; i < gs; i++) add_action(base, good_sync[i], 1'b0, 1'b1);
    end
    // With nothing to change the decision still closes with a bare end marker.
    if (expected_actions.size() == base) add_action(base, 0, 1'b0, 1'b0);
    expected_actions[$].last_action = 1'b1;
  endfunction

  // Takes one accepted replica into the shadow table; the last one of a table
  // triggers the decision, even when the table was already full and it is dropped.
  function automatic void absorb_replica(logic s, logic ok, logic [LAG_IN_W-1:0] lag,
                                         logic last);
    if (shadow_count < REPLICA_SLOTS) begin
      shadow_sync[shadow_count] = s;
      shadow_ok[shadow_count]   = ok;
      shadow_lag[shadow_count]  = lag;
      shadow_count++;
    end else begin
      shadow_overflow = 1'b1;
    end
    if (last) begin
      plan_mode_changes();
      shadow_count    = 0;
      shadow_overflow = 1'b0;
    end
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      failures++;
    end
  endfunction

  // Monitor: predicts on every accepted replica transaction, checks every accepted
  // result transaction against the oldest prediction, and keeps the watchdog.
  always @(posedge clk) begin : result_monitor
    mode_action_t want;
    logic         in_fire, out_fire;
    if (rst_n) begin
      in_fire  = in_ch.valid && in_ch.ready;
      out_fire = out_ch.valid && out_ch.ready;
      if (in_fire)
        absorb_replica(in_ch.is_sync, in_ch.check_ok, in_ch.lag, in_ch.last_replica);
      if (out_fire) begin
        if (expected_actions.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual index %0d mode %0b",
                   $time, out_ch.replica_index, out_ch.new_mode);
          failures++;
        end else begin
          want = expected_actions.pop_front();
          check_field("replica_index", 32'(want.replica_index), 32'(out_ch.replica_index));
          check_field("new_mode", 32'(want.new_mode), 32'(out_ch.new_mode));
          check_field("action_valid", 32'(want.action_valid), 32'(out_ch.action_valid));
          check_field("overflow", 32'(want.overflow), 32'(out_ch.overflow));
          check_field("last_action", 32'(want.last_action), 32'(out_ch.last_action));
        end
      end
      if (in_fire || out_fire || cfg_we) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: watchdog expired, no transaction for %0d cycles", $time, quiet_cycles);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // Offers one replica transaction after a random hold-off and returns at the
  // edge where it is accepted. The valid stays high so that back-to-back
  // transactions need no gap.
  task automatic send_replica(input logic s, input logic ok, input logic [LAG_IN_W-1:0] lag,
                              input logic last);
    while ($urandom_range(99, 0) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.is_sync      <= s;
    in_ch.check_ok     <= ok;
    in_ch.lag          <= lag;
    in_ch.last_replica <= last;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
  endtask

  // Lowers the valid and waits until every predicted result has arrived and the
  // loader is open again, then lets the block settle so that a register write
  // cannot overlap a decision.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (expected_actions.size() != 0 || in_ch.ready !== 1'b1);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Writes all five registers on consecutive edges, only while the block is idle.
  task automatic apply_settings(input logic en, input logic mg, input logic [LIM_W-1:0] mv,
                                input logic ng, input logic [LIM_W-1:0] nv);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_TRACKER_ENABLED;
    cfg_wdata <= {{(LIM_W-1){1'b0}}, en};
    @(posedge clk);
    cfg_index <= CFG_MAX_LIMIT_GIVEN;
    cfg_wdata <= {{(LIM_W-1){1'b0}}, mg};
    @(posedge clk);
    cfg_index <= CFG_MAX_SYNC_LIMIT;
    cfg_wdata <= mv;
    @(posedge clk);
    cfg_index <= CFG_MIN_LIMIT_GIVEN;
    cfg_wdata <= {{(LIM_W-1){1'b0}}, ng};
    @(posedge clk);
    cfg_index <= CFG_MIN_SYNC_LIMIT;
    cfg_wdata <= nv;
    @(posedge clk);
    cfg_we <= 1'b0;
    tracker_on = en;
    max_given  = mg;
    max_limit  = mv;
    min_given  = ng;
    min_limit  = nv;
  endtask

  // With the tracker off, a single-replica table yields only the bare end marker.
  task automatic test_disabled_marker();
    apply_settings(1'b0, 1'b0, 5'd16, 1'b0, 5'd0);
    send_replica(1'b1, 1'b1, 32'h0, 1'b1);
    wait_idle();
  endtask

  // Seventeen replicas: the store fills, the last one is dropped but still starts
  // the decision, and every result carries the overflow flag. Lags cover both
  // extremes and a run of equal values to exercise arrival-order tie-breaking.
  task automatic test_overflow_table();
    logic [LAG_IN_W-1:0] lag;
    apply_settings(1'b1, 1'b0, 5'd16, 1'b0, 5'd0);
    for (int i = 0; i <= REPLICA_SLOTS; i++) begin
      if (i == 0) lag = '0;
      else if (i == 1) lag = '1;
      else if (i < 8) lag = 32'd7;
      else lag = LAG_IN_W'(i);
      send_replica(i % 4 == 0, i % 5 != 2, lag, i == REPLICA_SLOTS);
    end
    wait_idle();
  endtask

  // Explicit limits: a maximum of one demotes the second healthy sync replica and,
  // with a minimum of zero, the unhealthy one too. A minimum of three then keeps
  // both unhealthy sync replicas while a healthy async one is promoted.
  task automatic test_limit_demotions();
    apply_settings(1'b1, 1'b1, 5'd1, 1'b1, 5'd0);
    send_replica(1'b1, 1'b1, 32'd5, 1'b0);
    send_replica(1'b1, 1'b1, 32'd7, 1'b0);
    send_replica(1'b1, 1'b0, 32'd9, 1'b0);
    send_replica(1'b0, 1'b1, 32'd3, 1'b1);
    wait_idle();
    apply_settings(1'b1, 1'b1, 5'd2, 1'b1, 5'd3);
    send_replica(1'b1, 1'b0, 32'd1, 1'b0);
    send_replica(1'b1, 1'b0, 32'd2, 1'b0);
    send_replica(1'b0, 1'b1, 32'd2, 1'b1);
    wait_idle();
  endtask

  // Random tables under one register setting and one idling pattern. Most tables
  // are short; a few fill the store or overrun it. Lags are drawn so that ties,
  // extremes and wide values all turn up.
  task automatic test_random_traffic(input int phase, input int items);
    int sent, size, roll;
    logic [LAG_IN_W-1:0] lag;
    case (phase % 4)
      0: begin idle_pct = 0;  stall_pct = 0;  end
      1: begin idle_pct = 53; stall_pct = 0;  end
      2: begin idle_pct = 0;  stall_pct = 53; end
      default: begin idle_pct = 38; stall_pct = 38; end
    endcase
    case (phase)
      0: apply_settings(1'b1, 1'b1, 5'd16, 1'b1, 5'd16);
      1: apply_settings(1'b1, 1'b1, 5'd0, 1'b1, 5'd0);
      2: apply_settings(1'b1, 1'b0, LIM_W'($urandom_range(16, 0)), 1'b0,
                        LIM_W'($urandom_range(16, 0)));
      3: apply_settings(1'b0, 1'($urandom_range(1, 0)), LIM_W'($urandom_range(16, 0)),
                        1'($urandom_range(1, 0)), LIM_W'($urandom_range(16, 0)));
      default: apply_settings(1'b1, 1'($urandom_range(1, 0)), LIM_W'($urandom_range(16, 0)),
                              1'($urandom_range(1, 0)), LIM_W'($urandom_range(16, 0)));
    endcase
    sent = 0;
    while (sent < items) begin
      roll = $urandom_range(99, 0);
      if (roll < 80) size = $urandom_range(8, 1);
      else if (roll < 94) size = $urandom_range(16, 9);
      else size = $urandom_range(20, 17);
      for (int k = 0; k < size; k++) begin
        case ($urandom_range(3, 0))
          0: lag = $urandom;
          1: lag = $urandom_range(3, 0);
          2: lag = $urandom_range(1, 0) ? '1 : '0;
          default: lag = $urandom >> $urandom_range(31, 0);
        endcase
        send_replica(1'($urandom_range(1, 0)), $urandom_range(3, 0) != 0, lag,
                     k == size - 1);
      end
      sent += size;
    end
    wait_idle();
  endtask

  // Test sequence: reset once, the directed cases with no idling, then the random
  // phases, which rotate through the idling patterns under changing settings.
  initial begin
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = CFG_TRACKER_ENABLED;
    cfg_wdata          = '0;
    in_ch.valid        = 1'b0;
    in_ch.is_sync      = 1'b0;
    in_ch.check_ok     = 1'b0;
    in_ch.lag          = '0;
    in_ch.last_replica = 1'b0;
    failures           = 0;
    quiet_cycles       = 0;
    idle_pct           = 0;
    stall_pct          = 0;
    shadow_count       = 0;
    shadow_overflow    = 1'b0;
    tracker_on         = 1'b0;
    max_given          = 1'b0;
    max_limit          = MAX_SYNC_LIMIT_RST;
    min_given          = 1'b0;
    min_limit          = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_disabled_marker();
    test_overflow_table();
    test_limit_demotions();
    for (int p = 0; p < PHASES; p++) test_random_traffic(p, RANDOM_ITEMS / PHASES);

    // Anything arriving now would be a result that nobody expected.
    repeat (END_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/rsms_pkg.sv
hw/rtl/rsms_if.sv
hw/rtl/replica_sync_mode_selector.sv
hw/rtl/rsms_checker.sv
sim/tb_replica_sync_mode_selector.sv
